// ===== rtl/core/mitensor_pkg.sv =====
// shared types and constants for the multipole interaction tensor entry core
// no dependencies; imported by multipole_interaction_tensor_entry_core
`default_nettype none

package mitensor_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int ENTRY_W       = 23;

  // interaction kinds
  localparam logic [2:0] KIND_DD = 3'd0;
  localparam logic [2:0] KIND_DQ = 3'd1;
  localparam logic [2:0] KIND_QD = 3'd2;
  localparam logic [2:0] KIND_QQ = 3'd3;
  localparam logic [2:0] KIND_DO = 3'd4;
  localparam logic [2:0] KIND_OD = 3'd5;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [4:0]  row_index;
    logic        [4:0]  col_index;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
  } item_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] entry_value;
    logic                      index_error;
  } result_t;

  typedef struct packed {
    logic [1:0] d2;
    logic [1:0] d1;
    logic [1:0] d0;
  } digits_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // base-3 digits of a 5-bit index by compare and subtract
  function automatic digits_t base3_digits(input logic [4:0] v);
    digits_t    d;
    logic [4:0] r;
    r = v;
    if (r >= 5'd18) begin
      d.d2 = 2'd2;
      r    = r - 5'd18;
    end else if (r >= 5'd9) begin
      d.d2 = 2'd1;
      r    = r - 5'd9;
    end else begin
      d.d2 = 2'd0;
    end
    if (r >= 5'd6) begin
      d.d1 = 2'd2;
      r    = r - 5'd6;
    end else if (r >= 5'd3) begin
      d.d1 = 2'd1;
      r    = r - 5'd3;
    end else begin
      d.d1 = 2'd0;
    end
    d.d0 = r[1:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/multipole_interaction_tensor_entry_core.sv =====
// cartesian multipole interaction tensor entry, five-stage pipeline
// depends on mitensor_pkg (word types, kind codes, digit split)
//
//   channel   valid          stall          word
//   input     item_valid     item_stall     item   (kind, row, column, ux, uy, uz)
//   output    result_valid   result_stall   result (entry_value, index_error)
//
// one word per cycle sustained while result is not stalled; a taken word passes through the stage registers in order
// stages: index decode, pair products, triple product and delta sums, quadruple product,
// combine and saturate into the output register
// rst clears the stage valid bits only; data registers are not reset
// a stall on result holds the full stages; empty stages ahead still fill, so bubbles close
`default_nettype none

module multipole_interaction_tensor_entry_core #(
  parameter int FRACTION_BITS = mitensor_pkg::FRAC_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_stall,
  input  mitensor_pkg::item_t    item,
  output logic                   result_valid,
  input  wire                    result_stall,
  output mitensor_pkg::result_t  result
);
  import mitensor_pkg::*;

  // product widths follow from the full 16-bit component bounds
  localparam int P2W = imax(32 - FRACTION_BITS, 2);
  localparam int P3W = imax(47 - 2 * FRACTION_BITS, 2);
  localparam int P4W = imax(62 - 3 * FRACTION_BITS, 2);
  localparam int M2W = 33;
  localparam int M3W = imax(P2W + 17, FRACTION_BITS + 2);
  localparam int M4W = imax(P3W + 17, FRACTION_BITS + 2);
  localparam int S6W = P2W + 3;
  localparam int SW  = imax(imax(P4W + 9, P2W + 9), imax(FRACTION_BITS + 7, 24));

  localparam logic signed [M2W-1:0] HALF2 = M2W'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [M3W-1:0] HALF3 = M3W'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [M4W-1:0] HALF4 = M4W'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [SW-1:0]  ONE   = SW'(1) <<< FRACTION_BITS;
  localparam logic signed [SW-1:0]  VMAX  = SW'(4194303);
  localparam logic signed [SW-1:0]  VMIN  = SW'(-4194304);

  localparam logic [1:0] RANK2 = 2'd0;
  localparam logic [1:0] RANK3 = 2'd1;
  localparam logic [1:0] RANK4 = 2'd2;

  // gates: bit0 d(i,j), bit1 d(i,q), bit2 d(j,q), bit3 d(k,q), bit4 d(k,j), bit5 d(k,i)
  typedef struct packed {
    logic [1:0] rank;
    logic       neg;
    logic       err;
    logic [5:0] gates;
    logic [1:0] d3;
  } ctl_t;

  function automatic logic signed [15:0] sel_comp(input logic [1:0] idx,
                                                  input logic signed [15:0] x,
                                                  input logic signed [15:0] y,
                                                  input logic signed [15:0] z);
    logic signed [15:0] v;
    case (idx)
      2'd0:    v = x;
      2'd1:    v = y;
      default: v = z;
    endcase
    return v;
  endfunction

  // stage handshake
  logic [5:1] vld;
  logic       adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !vld[5] || !result_stall;
  assign adv4 = !vld[4] || adv5;
  assign adv3 = !vld[3] || adv4;
  assign adv2 = !vld[2] || adv3;
  assign adv1 = !vld[1] || adv2;
  assign item_stall   = !adv1;
  assign result_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv1) vld[1] <= item_valid;
      if (adv2) vld[2] <= vld[1];
      if (adv3) vld[3] <= vld[2];
      if (adv4) vld[4] <= vld[3];
      if (adv5) vld[5] <= vld[4];
    end
  end

  // stage 1: split indices, pick components
  digits_t            rd, cd;
  logic [1:0]         q, j, i, k;
  ctl_t               ctl_d;
  ctl_t               c1;
  logic signed [15:0] s1_uq, s1_uj, s1_ui, s1_uk;

  always_comb begin
    rd = base3_digits(item.row_index);
    cd = base3_digits(item.col_index);
    q = 2'd0;
    j = 2'd0;
    i = 2'd0;
    k = 2'd0;
    ctl_d.rank = RANK4;
    ctl_d.neg  = 1'b0;
    ctl_d.err  = 1'b0;
    unique case (item.kind)
      KIND_DD: begin
        ctl_d.err  = (item.row_index >= 5'd3) || (item.col_index >= 5'd3);
        ctl_d.rank = RANK2;
        q = rd.d0;
        j = cd.d0;
      end
      KIND_DQ: begin
        ctl_d.err  = (item.row_index >= 5'd3) || (item.col_index >= 5'd9);
        ctl_d.rank = RANK3;
        q = rd.d0;
        j = cd.d1;
        i = cd.d0;
      end
      KIND_QD: begin
        ctl_d.err  = (item.row_index >= 5'd9) || (item.col_index >= 5'd3);
        ctl_d.rank = RANK3;
        ctl_d.neg  = 1'b1;
        q = rd.d1;
        j = rd.d0;
        i = cd.d0;
      end
      KIND_QQ: begin
        ctl_d.err = (item.row_index >= 5'd9) || (item.col_index >= 5'd9);
        q = rd.d1;
        j = rd.d0;
        i = cd.d1;
        k = cd.d0;
      end
      KIND_DO: begin
        ctl_d.err = (item.row_index >= 5'd3) || (item.col_index >= 5'd27);
        ctl_d.neg = 1'b1;
        q = rd.d0;
        j = cd.d2;
        i = cd.d1;
        k = cd.d0;
      end
      KIND_OD: begin
        ctl_d.err = (item.row_index >= 5'd27) || (item.col_index >= 5'd3);
        ctl_d.neg = 1'b1;
        q = rd.d2;
        j = rd.d1;
        i = rd.d0;
        k = cd.d0;
      end
      default: begin
        ctl_d.err = 1'b1;
      end
    endcase
    ctl_d.gates = {k == i, k == j, k == q, j == q, i == q, i == j};
    ctl_d.d3 = 2'({1'b0, (q == k) && (i == j)}) + 2'({1'b0, (i == k) && (j == q)})
             + 2'({1'b0, (j == k) && (i == q)});
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      c1    <= ctl_d;
      s1_uq <= sel_comp(q, item.ux, item.uy, item.uz);
      s1_uj <= sel_comp(j, item.ux, item.uy, item.uz);
      s1_ui <= sel_comp(i, item.ux, item.uy, item.uz);
      s1_uk <= sel_comp(k, item.ux, item.uy, item.uz);
    end
  end

  // stage 2: six pair products, rounded; order matches the gate bits
  // 0 qk, 1 jk, 2 ik, 3 ji, 4 qi, 5 qj
  logic signed [15:0]    op_a [6];
  logic signed [15:0]    op_b [6];
  logic signed [M2W-1:0] m2   [6];
  logic signed [P2W-1:0] p2   [6];
  logic signed [17:0]    t3;
  ctl_t                  c2;
  logic signed [P2W-1:0] s2_p2 [6];
  logic signed [15:0]    s2_ui, s2_uk;
  logic signed [17:0]    s2_t3;

  always_comb begin
    op_a[0] = s1_uq;  op_b[0] = s1_uk;
    op_a[1] = s1_uj;  op_b[1] = s1_uk;
    op_a[2] = s1_ui;  op_b[2] = s1_uk;
    op_a[3] = s1_uj;  op_b[3] = s1_ui;
    op_a[4] = s1_uq;  op_b[4] = s1_ui;
    op_a[5] = s1_uq;  op_b[5] = s1_uj;
    for (int n = 0; n < 6; n++) begin
      m2[n] = M2W'(op_a[n]) * M2W'(op_b[n]) + HALF2;
      p2[n] = P2W'(m2[n] >>> FRACTION_BITS);
    end
    // d(i,j)u_q + d(i,q)u_j + d(j,q)u_i
    t3 = (c1.gates[0] ? 18'(s1_uq) : 18'sd0) + (c1.gates[1] ? 18'(s1_uj) : 18'sd0)
       + (c1.gates[2] ? 18'(s1_ui) : 18'sd0);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      c2    <= c1;
      s2_p2 <= p2;
      s2_ui <= s1_ui;
      s2_uk <= s1_uk;
      s2_t3 <= t3;
    end
  end

  // stage 3: triple product, gated pair sum
  logic signed [M3W-1:0] m3;
  logic signed [S6W-1:0] s6;
  ctl_t                  c3;
  logic signed [P3W-1:0] s3_p3;
  logic signed [15:0]    s3_uk;
  logic signed [S6W-1:0] s3_s6;
  logic signed [17:0]    s3_t3;
  logic signed [P2W-1:0] s3_pqj;

  always_comb begin
    m3 = M3W'(s2_p2[5]) * M3W'(s2_ui) + HALF3;
    s6 = '0;
    for (int n = 0; n < 6; n++) begin
      if (c2.gates[n]) s6 = s6 + S6W'(s2_p2[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      c3     <= c2;
      s3_p3  <= P3W'(m3 >>> FRACTION_BITS);
      s3_uk  <= s2_uk;
      s3_s6  <= s6;
      s3_t3  <= s2_t3;
      s3_pqj <= s2_p2[5];
    end
  end

  // stage 4: quadruple product
  logic signed [M4W-1:0] m4;
  ctl_t                  c4;
  logic signed [P4W-1:0] s4_p4;
  logic signed [P3W-1:0] s4_p3;
  logic signed [S6W-1:0] s4_s6;
  logic signed [17:0]    s4_t3;
  logic signed [P2W-1:0] s4_pqj;

  assign m4 = M4W'(s3_p3) * M4W'(s3_uk) + HALF4;

  always_ff @(posedge clk) begin
    if (adv4) begin
      c4     <= c3;
      s4_p4  <= P4W'(m4 >>> FRACTION_BITS);
      s4_p3  <= s3_p3;
      s4_s6  <= s3_s6;
      s4_t3  <= s3_t3;
      s4_pqj <= s3_pqj;
    end
  end

  // stage 5: weigh, sign, saturate
  logic signed [SW-1:0] d3v;
  logic signed [SW-1:0] v;
  logic signed [SW-1:0] v_sat;
  result_t              result_next;

  always_comb begin
    d3v = SW'(c4.d3);
    case (c4.rank)
      RANK2: v = (c4.gates[2] ? ONE : SW'(0)) - SW'(3) * SW'(s4_pqj);
      RANK3: v = SW'(15) * SW'(s4_p3) - SW'(3) * SW'(s4_t3);
      default: begin
        v = SW'(105) * SW'(s4_p4) - SW'(15) * SW'(s4_s6) + SW'(3) * d3v * ONE;
      end
    endcase
    if (c4.neg) v = -v;
    if (v > VMAX) begin
      v_sat = VMAX;
    end else if (v < VMIN) begin
      v_sat = VMIN;
    end else begin
      v_sat = v;
    end
    if (c4.err) begin
      result_next.entry_value = '0;
      result_next.index_error = 1'b1;
    end else begin
      result_next.entry_value = ENTRY_W'(v_sat);
      result_next.index_error = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
